// ----- design/ordering_discipline_checker_top_assert.svh -----
`ifndef ORDERING_DISCIPLINE_CHECKER_TOP_ASSERT_SVH
`define ORDERING_DISCIPLINE_CHECKER_TOP_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define ODC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ordering checker: next-cycle property failed");

// consequent must hold in the same cycle as the antecedent
`define ODC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ordering checker: same-cycle property failed");

`endif

// ----- design/odc_pkg.sv -----
package odc_pkg;

  localparam int unsigned DEPTH_DEF      = 64;
  localparam int unsigned VALUE_BITS_DEF = 16;
  localparam int unsigned CMD_W          = 2;
  localparam int unsigned FIELD_W        = 16;
  localparam int unsigned VERDICT_W      = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } odc_cmd_e;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_STACK  = 3'd0,
    VERDICT_QUEUE  = 3'd1,
    VERDICT_PRIO   = 3'd2,
    VERDICT_NONE   = 3'd3,
    VERDICT_AMBIG  = 3'd4
  } odc_verdict_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_LOAD
  } odc_cell_op_e;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [FIELD_W-1:0] value;
  } odc_in_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic                 stack_fits;
    logic                 queue_fits;
    logic                 prio_fits;
    logic                 overflowed;
  } odc_res_t;

  // decoded operation handed to every chain
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } odc_op_t;

  // chain status back to the top level
  typedef struct packed {
    logic ok;
    logic ovf;
  } odc_stat_t;

endpackage

// ----- design/odc_cell.sv -----
module odc_cell #(
  parameter int unsigned VALUE_BITS = odc_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk_i,
  input  odc_pkg::odc_cell_op_e   op_i,
  input  logic [VALUE_BITS-1:0]   left_i,
  input  logic [VALUE_BITS-1:0]   right_i,
  input  logic [VALUE_BITS-1:0]   load_i,
  output logic [VALUE_BITS-1:0]   data_o
);
  import odc_pkg::*;

  logic [VALUE_BITS-1:0] data_q, data_d;

  always_comb begin
    case (op_i)
      CELL_FROM_LEFT:  data_d = left_i;
      CELL_FROM_RIGHT: data_d = right_i;
      CELL_LOAD:       data_d = load_i;
      default:         data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- design/odc_lifo.sv -----
module odc_lifo #(
  parameter int unsigned DEPTH      = odc_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_BITS = odc_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  odc_pkg::odc_op_t      op_i,
  input  logic [VALUE_BITS-1:0] val_i,
  output odc_pkg::odc_stat_t    stat_o
);
  import odc_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  ok_q, ok_d;
  logic                  full, empty, do_push, do_pop, match;
  logic [VALUE_BITS-1:0] data [DEPTH];

  assign full    = (cnt_q == CW'(DEPTH));
  assign empty   = (cnt_q == '0);
  assign match   = !empty && (data[0] == val_i);
  assign do_push = op_i.push && ok_q && !full;
  assign do_pop  = op_i.pop && ok_q && match;

  // top of stack sits in cell 0: push shifts right, pop shifts left
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    odc_cell_op_e          cop;
    logic [VALUE_BITS-1:0] left_w, right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = data[i+1];
    end

    always_comb begin
      cop = CELL_HOLD;
      if (do_push) begin
        cop = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
      end else if (do_pop) begin
        cop = CELL_FROM_RIGHT;
      end
    end

    odc_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
      .clk_i  (clk_i),
      .op_i   (cop),
      .left_i (left_w),
      .right_i(right_w),
      .load_i (val_i),
      .data_o (data[i])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    ok_d  = ok_q;
    if (op_i.clear) begin
      cnt_d = '0;
      ok_d  = 1'b1;
    end else if (do_push) begin
      cnt_d = cnt_q + CW'(1);
    end else if (op_i.pop && ok_q) begin
      if (match) begin
        cnt_d = cnt_q - CW'(1);
      end else begin
        ok_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ok_q  <= 1'b1;
    end else begin
      cnt_q <= cnt_d;
      ok_q  <= ok_d;
    end
  end

  assign stat_o.ok  = ok_q;
  assign stat_o.ovf = op_i.push && ok_q && full;

endmodule

// ----- design/odc_fifo.sv -----
module odc_fifo #(
  parameter int unsigned DEPTH      = odc_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_BITS = odc_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  odc_pkg::odc_op_t      op_i,
  input  logic [VALUE_BITS-1:0] val_i,
  output odc_pkg::odc_stat_t    stat_o
);
  import odc_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  ok_q, ok_d;
  logic                  full, empty, do_push, do_pop, match;
  logic [VALUE_BITS-1:0] data [DEPTH];

  assign full    = (cnt_q == CW'(DEPTH));
  assign empty   = (cnt_q == '0);
  assign match   = !empty && (data[0] == val_i);
  assign do_push = op_i.push && ok_q && !full;
  assign do_pop  = op_i.pop && ok_q && match;

  // head sits in cell 0; a push lands in the first free cell
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    odc_cell_op_e          cop;
    logic [VALUE_BITS-1:0] right_w;

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = data[i+1];
    end

    always_comb begin
      cop = CELL_HOLD;
      if (do_push && (cnt_q == CW'(i))) begin
        cop = CELL_LOAD;
      end else if (do_pop) begin
        cop = CELL_FROM_RIGHT;
      end
    end

    odc_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
      .clk_i  (clk_i),
      .op_i   (cop),
      .left_i ('0),
      .right_i(right_w),
      .load_i (val_i),
      .data_o (data[i])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    ok_d  = ok_q;
    if (op_i.clear) begin
      cnt_d = '0;
      ok_d  = 1'b1;
    end else if (do_push) begin
      cnt_d = cnt_q + CW'(1);
    end else if (op_i.pop && ok_q) begin
      if (match) begin
        cnt_d = cnt_q - CW'(1);
      end else begin
        ok_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ok_q  <= 1'b1;
    end else begin
      cnt_q <= cnt_d;
      ok_q  <= ok_d;
    end
  end

  assign stat_o.ok  = ok_q;
  assign stat_o.ovf = op_i.push && ok_q && full;

endmodule

// ----- design/odc_prio.sv -----
module odc_prio #(
  parameter int unsigned DEPTH      = odc_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_BITS = odc_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  odc_pkg::odc_op_t      op_i,
  input  logic [VALUE_BITS-1:0] val_i,
  output odc_pkg::odc_stat_t    stat_o
);
  import odc_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  ok_q, ok_d;
  logic                  full, empty, do_push, do_pop, match;
  logic [VALUE_BITS-1:0] data [DEPTH];
  logic [DEPTH-1:0]      occ, take;

  assign full    = (cnt_q == CW'(DEPTH));
  assign empty   = (cnt_q == '0);
  assign match   = !empty && (data[0] == val_i);
  assign do_push = op_i.push && ok_q && !full;
  assign do_pop  = op_i.pop && ok_q && match;

  // cells kept sorted largest first, so cell 0 always holds the maximum
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    odc_cell_op_e          cop;
    logic [VALUE_BITS-1:0] left_w, right_w;
    logic                  take_prev, occ_prev;

    assign occ[i]  = (CW'(i) < cnt_q);
    assign take[i] = !occ[i] || (val_i > data[i]);

    if (i == 0) begin : g_first
      assign left_w    = '0;
      assign take_prev = 1'b0;
      assign occ_prev  = 1'b0;
    end else begin : g_inner_l
      assign left_w    = data[i-1];
      assign take_prev = take[i-1];
      assign occ_prev  = occ[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = data[i+1];
    end

    always_comb begin
      cop = CELL_HOLD;
      if (do_push) begin
        // entries below the insert point move down one cell
        if (take_prev && occ_prev) begin
          cop = CELL_FROM_LEFT;
        end else if (take[i] && !take_prev) begin
          cop = CELL_LOAD;
        end
      end else if (do_pop) begin
        cop = CELL_FROM_RIGHT;
      end
    end

    odc_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
      .clk_i  (clk_i),
      .op_i   (cop),
      .left_i (left_w),
      .right_i(right_w),
      .load_i (val_i),
      .data_o (data[i])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    ok_d  = ok_q;
    if (op_i.clear) begin
      cnt_d = '0;
      ok_d  = 1'b1;
    end else if (do_push) begin
      cnt_d = cnt_q + CW'(1);
    end else if (op_i.pop && ok_q) begin
      if (match) begin
        cnt_d = cnt_q - CW'(1);
      end else begin
        ok_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ok_q  <= 1'b1;
    end else begin
      cnt_q <= cnt_d;
      ok_q  <= ok_d;
    end
  end

  assign stat_o.ok  = ok_q;
  assign stat_o.ovf = op_i.push && ok_q && full;

endmodule

// ----- design/ordering_discipline_checker_top.sv -----
// Ordering discipline checker.
// Input channel: an operation (cmd, value) transfers at a clock edge where start is high
// and busy is low. cmd selects push, pop with the observed value, or clear; other codes
// leave the state alone and just report it.
// busy stays low, so one operation transfers every cycle.
// Output channel: res_valid_o is high for exactly one cycle, the cycle right after the
// operation transferred, and res_o then holds the verdict, the three fit
// flags and the sticky overflow flag as they stand after that operation.
// The receiver has no way to stall; each result transfers at the edge ending its cycle.
// Throughput is one operation per cycle: every structure is a chain of cells that shift
// or load in one step, with the head of each chain in cell 0, so a pop compares only
// cell 0 and the priority chain keeps itself sorted on insertion.
// Reset (rst_ni low) empties all chains, sets the three fit flags, clears the overflow
// flag and drops res_valid_o. Cell contents are not reset; empty cells are never read.
module ordering_discipline_checker_top #(
  parameter int unsigned DEPTH      = odc_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_BITS = odc_pkg::VALUE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  odc_pkg::odc_in_t  in_i,
  output logic              res_valid_o,
  output odc_pkg::odc_res_t res_o
);
  import odc_pkg::*;

  logic                  accept;
  logic [VALUE_BITS-1:0] val;
  odc_op_t               op;
  odc_stat_t             lifo_stat, fifo_stat, prio_stat;
  logic                  ovf_q, ovf_d;
  logic                  res_valid_q;
  logic [1:0]            n_fits;
  odc_verdict_e          verdict;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign val    = VALUE_BITS'(in_i.value);

  assign op.push  = accept && (in_i.cmd == CMD_PUSH);
  assign op.pop   = accept && (in_i.cmd == CMD_POP);
  assign op.clear = accept && (in_i.cmd == CMD_CLEAR);

  odc_lifo #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_lifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .op_i  (op),
    .val_i (val),
    .stat_o(lifo_stat)
  );

  odc_fifo #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .op_i  (op),
    .val_i (val),
    .stat_o(fifo_stat)
  );

  odc_prio #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_prio (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .op_i  (op),
    .val_i (val),
    .stat_o(prio_stat)
  );

  always_comb begin
    ovf_d = ovf_q;
    if (op.clear) begin
      ovf_d = 1'b0;
    end else if (lifo_stat.ovf || fifo_stat.ovf || prio_stat.ovf) begin
      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      ovf_q       <= ovf_d;
      res_valid_q <= accept;
    end
  end

  // chain flags are registers already updated by the transfer, so read them directly
  assign n_fits = {1'b0, lifo_stat.ok} + {1'b0, fifo_stat.ok} + {1'b0, prio_stat.ok};

  always_comb begin
    if (n_fits > 2'd1) begin
      verdict = VERDICT_AMBIG;
    end else if (n_fits == 2'd0) begin
      verdict = VERDICT_NONE;
    end else if (lifo_stat.ok) begin
      verdict = VERDICT_STACK;
    end else if (prio_stat.ok) begin
      verdict = VERDICT_PRIO;
    end else begin
      verdict = VERDICT_QUEUE;
    end
  end

  assign res_o.verdict    = verdict;
  assign res_o.stack_fits = lifo_stat.ok;
  assign res_o.queue_fits = fifo_stat.ok;
  assign res_o.prio_fits  = prio_stat.ok;
  assign res_o.overflowed = ovf_q;
  assign res_valid_o      = res_valid_q;

endmodule

// ----- design/odc_checker.sv -----
`include "ordering_discipline_checker_top_assert.svh"

module odc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input odc_pkg::odc_in_t  in_i,
  input logic              res_valid_o,
  input odc_pkg::odc_res_t res_o
);
  import odc_pkg::*;

  logic xfer;
  logic one_fit;
  logic clear_xfer;
  logic fresh_status;
  logic single_verdict;

  assign xfer    = start && !busy;
  assign one_fit = $onehot({res_o.stack_fits, res_o.queue_fits, res_o.prio_fits});

  assign clear_xfer   = xfer && (in_i.cmd == CMD_CLEAR);
  assign fresh_status = res_o.stack_fits && res_o.queue_fits && res_o.prio_fits &&
                        !res_o.overflowed && (res_o.verdict == VERDICT_AMBIG);
  assign single_verdict = (res_o.verdict == VERDICT_STACK) ||
                          (res_o.verdict == VERDICT_QUEUE) ||
                          (res_o.verdict == VERDICT_PRIO);

  `ODC_ASSERT_NEXT(a_res_follows, xfer, res_valid_o)
  `ODC_ASSERT_NEXT(a_no_spurious_res, !xfer, !res_valid_o)
  `ODC_ASSERT_NEXT(a_clear_restarts, clear_xfer, fresh_status)
  `ODC_ASSERT_SAME(a_single_verdict, res_valid_o && one_fit, single_verdict)

endmodule

bind ordering_discipline_checker_top odc_checker u_odc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .in_i       (in_i),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);
